// ===== design/cv3_pkg.sv =====
// Shared types and constants for the 3x3 convolution line buffer.
// Used by cv3_window, cv3_mac and conv3x3_line_buffer; depends on nothing.
`timescale 1ns / 1ps

package cv3_pkg;

  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int TAPS   = 9;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd4;

  localparam int CFG_DATA_W = 48;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;

  // Arithmetic widths: 9-bit signed pixel times 16-bit coefficient,
  // three products per kernel row, three rows in the total.
  localparam int PROD_W = 25;
  localparam int RSUM_W = 27;
  localparam int SUM_W  = 29;

  // Output queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [TAPS-1:0] win_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [TAPS-1:0] coef_arr_t;

  // Per-word flags that travel down the pipeline with the pixel.
  typedef struct packed {
    logic produce;
    logic row_last;
    logic frame_last;
  } tag_t;

  // One entry of the output queue.
  typedef struct packed {
    logic frame_last;
    logic row_last;
    logic saturated;
    pix_t pixel;
  } result_t;

endpackage

// ===== design/cv3_window.sv =====
// Line store memory with read-modify-write and forwarding, plus the 3x3 window.
// Depends on cv3_pkg.
`timescale 1ns / 1ps

module cv3_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             a_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]     a_addr,
  input  cv3_pkg::pix_t                    a_pix,
  input  cv3_pkg::tag_t                    a_tag,
  output logic                             w_valid,
  output cv3_pkg::win_t                    w_win,
  output cv3_pkg::tag_t                    w_tag,
  output logic [1:0]                       busy_cnt
);

  localparam int AW = $clog2(MAX_WIDTH);

  // Each entry holds the row two back in the upper byte and the previous row below.
  logic [2*cv3_pkg::PIX_W-1:0] mem [MAX_WIDTH];

  logic [2*cv3_pkg::PIX_W-1:0] rd_q_r;
  logic                        fwd_hit_r;
  logic [2*cv3_pkg::PIX_W-1:0] fwd_data_r;
  logic                        b_valid_r;
  logic [AW-1:0]               b_addr_r;
  cv3_pkg::pix_t               b_pix_r;
  cv3_pkg::tag_t               b_tag_r;
  cv3_pkg::pix_t               wp_r [6];
  logic                        c_valid_r;
  cv3_pkg::win_t               c_win_r;
  cv3_pkg::tag_t               c_tag_r;

  logic [2*cv3_pkg::PIX_W-1:0] line;
  cv3_pkg::pix_t               b_up;
  cv3_pkg::pix_t               b_mid;
  cv3_pkg::win_t               win_nxt;

  // The previous word writes the entry at the same edge as this one reads it,
  // so a back-to-back hit takes the data from the forwarding register.
  assign line  = fwd_hit_r ? fwd_data_r : rd_q_r;
  assign b_up  = line[2*cv3_pkg::PIX_W-1:cv3_pkg::PIX_W];
  assign b_mid = line[cv3_pkg::PIX_W-1:0];

  always_comb begin
    for (int ky = 0; ky < 3; ky++) begin
      win_nxt[3*ky]     = wp_r[ky];
      win_nxt[3*ky + 1] = wp_r[3 + ky];
    end
    win_nxt[2] = b_up;
    win_nxt[5] = b_mid;
    win_nxt[8] = b_pix_r;
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      rd_q_r     <= mem[a_addr];
      fwd_data_r <= {b_mid, b_pix_r};
    end
    if (b_valid_r) begin
      mem[b_addr_r] <= {b_mid, b_pix_r};
    end
    b_addr_r <= a_addr;
    b_pix_r  <= a_pix;
    b_tag_r  <= a_tag;
    c_win_r  <= win_nxt;
    c_tag_r  <= b_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        wp_r[i] <= '0;
      end
    end else begin
      b_valid_r <= a_valid;
      c_valid_r <= b_valid_r;
      if (a_valid) begin
        fwd_hit_r <= b_valid_r && (b_addr_r == a_addr);
      end
      if (b_valid_r) begin
        wp_r[0] <= wp_r[3];
        wp_r[1] <= wp_r[4];
        wp_r[2] <= wp_r[5];
        wp_r[3] <= b_up;
        wp_r[4] <= b_mid;
        wp_r[5] <= b_pix_r;
      end
    end
  end

  assign w_valid  = c_valid_r;
  assign w_win    = c_win_r;
  assign w_tag    = c_tag_r;
  assign busy_cnt = {1'b0, b_valid_r} + {1'b0, c_valid_r};

endmodule

// ===== design/cv3_mac.sv =====
// Nine-tap multiply, row sums, total, rounding and saturation to 8 bits.
// Depends on cv3_pkg.
`timescale 1ns / 1ps

module cv3_mac #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 w_valid,
  input  cv3_pkg::win_t        w_win,
  input  cv3_pkg::tag_t        w_tag,
  input  cv3_pkg::coef_arr_t   coef,
  output logic                 o_valid,
  output cv3_pkg::result_t     o_result,
  output logic [1:0]           busy_cnt
);

  localparam int PW = cv3_pkg::PROD_W;
  localparam int RW = cv3_pkg::RSUM_W;
  localparam int SW = cv3_pkg::SUM_W;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [PW-1:0] prod_r [cv3_pkg::TAPS];
  logic                 p_valid_r;
  cv3_pkg::tag_t        p_tag_r;
  logic signed [RW-1:0] rsum_r [3];
  logic                 s_valid_r;
  cv3_pkg::tag_t        s_tag_r;

  logic signed [SW-1:0] total;
  logic signed [SW-1:0] shifted;
  cv3_pkg::pix_t        val;
  logic                 sat;

  always_ff @(posedge clk) begin
    for (int i = 0; i < cv3_pkg::TAPS; i++) begin
      prod_r[i] <= $signed({1'b0, w_win[i]}) * coef[i];
    end
    for (int k = 0; k < 3; k++) begin
      rsum_r[k] <= RW'(prod_r[3*k]) + RW'(prod_r[3*k + 1]) + RW'(prod_r[3*k + 2]);
    end
    p_tag_r <= w_tag;
    s_tag_r <= p_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      p_valid_r <= w_valid;
      s_valid_r <= p_valid_r;
    end
  end

  // Round half up, floor-shift, then clip to the pixel range.
  always_comb begin
    total   = SW'(rsum_r[0]) + SW'(rsum_r[1]) + SW'(rsum_r[2]) + HALF;
    shifted = total >>> COEF_FRAC_BITS;
    if (total < 0) begin
      val = '0;
      sat = 1'b1;
    end else if (|shifted[SW-1:cv3_pkg::PIX_W]) begin
      val = '1;
      sat = 1'b1;
    end else begin
      val = shifted[cv3_pkg::PIX_W-1:0];
      sat = 1'b0;
    end
  end

  assign o_valid             = s_valid_r && s_tag_r.produce;
  assign o_result.pixel      = val;
  assign o_result.saturated  = sat;
  assign o_result.row_last   = s_tag_r.row_last;
  assign o_result.frame_last = s_tag_r.frame_last;
  assign busy_cnt            = {1'b0, p_valid_r} + {1'b0, s_valid_r};

endmodule

// ===== design/conv3x3_line_buffer.sv =====
// Top level of the 3x3 convolution line buffer: counters, registers, output queue.
// Depends on cv3_pkg, cv3_window and cv3_mac.
`timescale 1ns / 1ps

// Pixels enter in raster order on the in_ stream, one word per pixel, with
// in_tuser set on the first pixel of a frame (it forces row 0, column 0).
// Every input word from row 2 and column 2 onwards yields one output word
// with the rounded, saturated 3x3 sum for the window ending at that pixel;
// earlier words yield nothing. out_tlast marks the last output of a row and
// out_tuser carries the saturation flag and the end-of-frame flag.
// Kernel coefficients and image size are written through the cfg_ port,
// which is always ready; writes are expected only while the block is idle.
// Throughput is one word per cycle while in_tready is high. The line store
// read happens at the edge that accepts an input word, and its output word
// is registered at window, multiply and row sums, then queued. The line stores
// are a single memory read and written once per word, with a forwarding
// register for the case where the same column is touched by consecutive words.
// in_tready is a credit check: it drops when the eight-entry output queue
// plus the words in flight could fill it, so a stalled receiver backs the
// stream up without losing a word. Reset clears the counters, window,
// pipeline and queue and restores the default registers; the line store
// contents are not cleared and need no clearing pass.
module conv3x3_line_buffer #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cv3_pkg::PIX_W-1:0]         in_tdata,   // [7:0] pixel_in
  input  logic                              in_tuser,   // [0] frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cv3_pkg::PIX_W-1:0]         out_tdata,  // [7:0] pixel_out
  output logic                              out_tlast,  // row_last
  output logic [1:0]                        out_tuser,  // [0] saturated, [1] frame_last
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cv3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cv3_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > cv3_pkg::WIDTH_W) ?
                       $clog2(MAX_WIDTH + 1) : cv3_pkg::WIDTH_W;
  localparam int HW  = cv3_pkg::HEIGHT_W;
  localparam int FAW = cv3_pkg::FIFO_AW;

  // Configuration registers.
  logic [cv3_pkg::CFG_DATA_W-1:0] coef_row_r [3];
  logic [cv3_pkg::WIDTH_W-1:0]    image_width_r;
  logic [HW-1:0]                  image_height_r;

  // Position of the next pixel.
  logic [AW-1:0] col_cnt_r;
  logic [HW-1:0] row_cnt_r;
  logic [AW-1:0] col_cnt_nxt;
  logic [HW-1:0] row_cnt_nxt;

  // Output queue.
  cv3_pkg::result_t   fifo_mem [cv3_pkg::FIFO_DEPTH];
  logic [FAW-1:0]     wr_ptr_r;
  logic [FAW-1:0]     rd_ptr_r;
  logic [FAW:0]       fifo_cnt_r;

  logic               in_acc;
  logic [AW-1:0]      col;
  logic [HW-1:0]      row;
  logic [WW-1:0]      width_ext;
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;
  logic               row_end;
  logic               frame_end;
  cv3_pkg::tag_t      a_tag;
  cv3_pkg::coef_arr_t coef;

  logic               w_valid;
  cv3_pkg::win_t      w_win;
  cv3_pkg::tag_t      w_tag;
  logic [1:0]         w_busy;
  logic               push;
  logic               pop;
  cv3_pkg::result_t   push_data;
  cv3_pkg::result_t   head;
  logic [1:0]         m_busy;
  logic [FAW+1:0]     used;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  // Effective sizes: width clamped to 3..MAX_WIDTH, height to at least 3.
  always_comb begin
    width_ext = WW'(image_width_r);
    if (width_ext < WW'(3)) begin
      w_eff = WW'(3);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    h_eff = (image_height_r < HW'(3)) ? HW'(3) : image_height_r;
  end

  // Stage A: place the pixel in the frame and decide its flags.
  always_comb begin
    col       = in_tuser ? '0 : col_cnt_r;
    row       = in_tuser ? '0 : row_cnt_r;
    row_end   = (WW'(col) + WW'(1)) >= w_eff;
    frame_end = row_end && ((({1'b0, row}) + (HW + 1)'(1)) >= {1'b0, h_eff});
    a_tag.produce    = (row >= HW'(2)) && (col >= AW'(2));
    a_tag.row_last   = row_end;
    a_tag.frame_last = frame_end;
    if (row_end) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = frame_end ? '0 : row + HW'(1);
    end else begin
      col_cnt_nxt = col + AW'(1);
      row_cnt_nxt = row;
    end
  end

  always_comb begin
    for (int ky = 0; ky < 3; ky++) begin
      for (int kx = 0; kx < 3; kx++) begin
        coef[3*ky + kx] = coef_row_r[ky][cv3_pkg::COEF_W*kx +: cv3_pkg::COEF_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_row_r[0]  <= '0;
      coef_row_r[1]  <= cv3_pkg::CFG_DATA_W'(48'h0000_4000_0000);
      coef_row_r[2]  <= '0;
      image_width_r  <= cv3_pkg::WIDTH_W'(640);
      image_height_r <= HW'(480);
      col_cnt_r      <= '0;
      row_cnt_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cv3_pkg::CFG_COEF_TOP:    coef_row_r[0]  <= cfg_data;
          cv3_pkg::CFG_COEF_MID:    coef_row_r[1]  <= cfg_data;
          cv3_pkg::CFG_COEF_BOTTOM: coef_row_r[2]  <= cfg_data;
          cv3_pkg::CFG_WIDTH:       image_width_r  <= cfg_data[cv3_pkg::WIDTH_W-1:0];
          cv3_pkg::CFG_HEIGHT:      image_height_r <= cfg_data[HW-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
    end
  end

  cv3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .a_valid  (in_acc),
    .a_addr   (col),
    .a_pix    (in_tdata),
    .a_tag    (a_tag),
    .w_valid  (w_valid),
    .w_win    (w_win),
    .w_tag    (w_tag),
    .busy_cnt (w_busy)
  );

  cv3_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .w_valid  (w_valid),
    .w_win    (w_win),
    .w_tag    (w_tag),
    .coef     (coef),
    .o_valid  (push),
    .o_result (push_data),
    .busy_cnt (m_busy)
  );

  // Output queue. A word is only accepted when the queue has room for it
  // and for every word already in the pipeline.
  assign pop  = out_tvalid && out_tready;
  assign used = (FAW + 2)'(fifo_cnt_r) + (FAW + 2)'(w_busy) + (FAW + 2)'(m_busy);
  assign in_tready = used < (FAW + 2)'(cv3_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FAW'(1);
      end
      if (push && !pop) begin
        fifo_cnt_r <= fifo_cnt_r + (FAW + 1)'(1);
      end else if (pop && !push) begin
        fifo_cnt_r <= fifo_cnt_r - (FAW + 1)'(1);
      end
    end
  end

  assign head         = fifo_mem[rd_ptr_r];
  assign out_tvalid   = fifo_cnt_r != '0;
  assign out_tdata    = head.pixel;
  assign out_tlast    = head.row_last;
  assign out_tuser[0] = head.saturated;
  assign out_tuser[1] = head.frame_last;

`ifndef NO_ASSERTIONS
  // The credit check must keep the queue from ever overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (fifo_cnt_r < (FAW + 1)'(cv3_pkg::FIFO_DEPTH)))
    else $error("output queue overflow");

  // The end of a frame is always also the end of a row.
  a_frame_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tlast))
    else $error("frame_last without row_last");

  // A frame start puts the next pixel at column 1.
  a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (col_cnt_r == AW'(1)))
    else $error("column counter wrong after frame start");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for conv3x3_line_buffer: a directed table, then random frames.
// Depends on cv3_pkg and the conv3x3_line_buffer RTL; needs no other file.
`timescale 1ns / 1ps

module testbench;
  import cv3_pkg::*;

  localparam int LINE_MAX     = 1024;
  localparam int FRAC_BITS    = 14;
  localparam int DRAIN_CYCLES = 16;       // well past the time a word spends in the pipeline
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 450;
  localparam int WIDE_PHASE   = 3;        // a short run at the widest line
  localparam int TALL_PHASE   = 5;        // height at its maximum, left mid-frame
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_HEIGHT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  typedef enum {STEP_WRITE, STEP_PIXEL} step_kind_e;
  typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} check_e;
  typedef enum {RX_OPEN, RX_CHOPPY, RX_CLOGGED} rx_pace_e;
  typedef enum {TONE_ANY, TONE_EXTREME, TONE_SMOOTH} tone_e;

  typedef struct {
    step_kind_e               kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    pix_t                     pix;
    logic                     sof;
    check_e                   chk;
    result_t                  want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  conv3x3_line_buffer #(
    .MAX_WIDTH      (LINE_MAX),
    .COEF_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the block: registers, line stores, window and raster counters.
  logic [CFG_DATA_W-1:0] coef_row [3] = '{48'd0, 48'h0000_4000_0000, 48'd0};
  logic [WIDTH_W-1:0]    img_w = 11'd640;
  logic [HEIGHT_W-1:0]   img_h = 16'd480;
  pix_t                  upper_line  [LINE_MAX];
  pix_t                  middle_line [LINE_MAX];
  pix_t                  win_hist [6] = '{default: '0};
  int unsigned           col_cnt = 0;
  int unsigned           row_cnt = 0;

  result_t  awaited_results [$];
  int       fault_count = 0;
  int       words_out = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       tx_gappy = 1'b0;
  rx_pace_e rx_mode = RX_OPEN;
  int       hold_left = 0;

  function automatic int unsigned eff_width(logic [WIDTH_W-1:0] w);
    if (w < 3) return 3;
    if (w > LINE_MAX) return LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned eff_height(logic [HEIGHT_W-1:0] h);
    return (h < 3) ? 3 : h;
  endfunction

  function automatic void log_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  task automatic mirror_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_COEF_TOP:    coef_row[0] = d;
      CFG_COEF_MID:    coef_row[1] = d;
      CFG_COEF_BOTTOM: coef_row[2] = d;
      CFG_WIDTH:       img_w = d[WIDTH_W-1:0];
      CFG_HEIGHT:      img_h = d[HEIGHT_W-1:0];
      default: ;       // unused indexes change nothing
    endcase
  endtask

  // Advances the mirror by one accepted pixel and works out the output word,
  // if this pixel completes a window inside the valid region.
  task automatic window_sum_step(input pix_t p, input logic sof,
                                 output bit produced, output result_t res);
    int unsigned w, h, c, r;
    pix_t        up, mid;
    pix_t        tap [3][3];
    bit          row_end, frame_end;
    longint      acc, coef, px;
    w = eff_width(img_w);
    h = eff_height(img_h);
    if (sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
    r = row_cnt;
    up = upper_line[c];
    mid = middle_line[c];
    row_end = (c + 1 >= w);
    frame_end = row_end && (r + 1 >= h);
    produced = (r >= 2 && c >= 2);
    res = '0;
    if (produced) begin
      for (int ky = 0; ky < 3; ky++) begin
        tap[ky][0] = win_hist[ky];
        tap[ky][1] = win_hist[3 + ky];
      end
      tap[0][2] = up;
      tap[1][2] = mid;
      tap[2][2] = p;
      acc = 0;
      for (int ky = 0; ky < 3; ky++) begin
        for (int kx = 0; kx < 3; kx++) begin
          coef = $signed(coef_row[ky][16*kx +: 16]);
          px = tap[ky][kx];
          acc += px * coef;
        end
      end
      // Round half up, then floor-shift and clip to the pixel range.
      acc += longint'(1) << (FRAC_BITS - 1);
      if (acc < 0) begin
        res.pixel = '0;
        res.saturated = 1'b1;
      end else if ((acc >>> FRAC_BITS) > 255) begin
        res.pixel = 8'hFF;
        res.saturated = 1'b1;
      end else begin
        res.pixel = pix_t'(acc >>> FRAC_BITS);
      end
      res.row_last = row_end;
      res.frame_last = frame_end;
    end
    upper_line[c] = mid;
    middle_line[c] = p;
    for (int k = 0; k < 3; k++) win_hist[k] = win_hist[k + 3];
    win_hist[3] = up;
    win_hist[4] = mid;
    win_hist[5] = p;
    if (row_end) begin
      col_cnt = 0;
      row_cnt = frame_end ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // Offers one pixel word from a falling edge and returns at the falling
  // edge after it was taken. Valid stays high between words of a burst.
  task automatic send_pixel(input pix_t p, input logic sof,
                            input check_e chk, input result_t typed);
    bit      produced;
    result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_gappy) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_tdata = p;
    in_tuser = sof;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    window_sum_step(p, sof, produced, res);
    case (chk)
      CHK_MODEL: if (produced) awaited_results.push_back(res);
      CHK_TYPED: awaited_results.push_back(typed);
      default: ;
    endcase
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_index = idx;
    cfg_data = d;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror_write(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops the stream and waits until the block has nothing left in flight.
  task automatic settle();
    in_tvalid = 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic step_t write_step(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] d);
    step_t s;
    s = '{kind: STEP_WRITE, idx: idx, data: d, pix: '0, sof: 1'b0,
          chk: CHK_NONE, want: '0};
    return s;
  endfunction

  function automatic step_t pixel_step(pix_t p, logic sof, check_e chk,
                                       result_t want);
    step_t s;
    s = '{kind: STEP_PIXEL, idx: '0, data: '0, pix: p, sof: sof,
          chk: chk, want: want};
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] make_coef_row();
    logic [CFG_DATA_W-1:0] row;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 4))
        0:       row[16*k +: 16] = 16'($urandom_range(0, 4096)) - 16'd2048;
        1:       row[16*k +: 16] = 16'($urandom);
        2:       row[16*k +: 16] = 16'd1820;    // close to one ninth
        3:       row[16*k +: 16] = 16'd0;
        default: row[16*k +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      endcase
    end
    return row;
  endfunction

  function automatic pix_t make_pixel(tone_e tone);
    case (tone)
      TONE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      TONE_SMOOTH:  return pix_t'(8'd96 + $urandom_range(0, 63));
      default:      return pix_t'($urandom);
    endcase
  endfunction

  // Receiver pacing: open, choppy random stalls, or rare long stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_CHOPPY: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            hold_left <= $urandom_range(4, 30);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{frame_last: out_tuser[1], row_last: out_tlast,
              saturated: out_tuser[0], pixel: out_tdata};
      if (awaited_results.size() == 0) begin
        log_fault($sformatf("unexpected output word: pixel %0d sat %b row %b frame %b",
                            got.pixel, got.saturated, got.row_last, got.frame_last));
      end else begin
        want = awaited_results.pop_front();
        if (got.pixel !== want.pixel || got.saturated !== want.saturated ||
            got.row_last !== want.row_last || got.frame_last !== want.frame_last) begin
          log_fault($sformatf({"output word %0d: expected pixel %0d sat %b row %b frame %b,",
                               " got pixel %0d sat %b row %b frame %b"},
                              words_out, want.pixel, want.saturated, want.row_last,
                              want.frame_last, got.pixel, got.saturated, got.row_last,
                              got.frame_last));
        end
      end
      words_out++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    step_t              plan [$];
    bit                 pixels_sent;
    int unsigned        ph, rnd_words, words, old_w, w_e, h_e;
    logic [WIDTH_W-1:0] new_w;
    logic [HEIGHT_W-1:0] new_h;
    bit                 write_w, write_h, need_sof;
    logic               sof;
    tone_e              tone;
    int                 pick;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_COEF_TOP;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Default kernel is the identity, so a 3x3 image gives back its centre.
    plan.push_back(write_step(CFG_WIDTH, 48'd3));
    plan.push_back(pixel_step(8'd10, 1'b1, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd20, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd30, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd40, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd50, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd60, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd70, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd80, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd90, 1'b0, CHK_TYPED,
        '{frame_last: 1'b0, row_last: 1'b1, saturated: 1'b0, pixel: 8'd50}));
    // Sizes below the minimum clamp to 3x3; all taps at the largest positive value.
    plan.push_back(write_step(CFG_HEIGHT, 48'd0));
    plan.push_back(write_step(CFG_WIDTH, 48'd0));
    plan.push_back(write_step(CFG_COEF_TOP, 48'h7FFF_7FFF_7FFF));
    plan.push_back(write_step(CFG_COEF_MID, 48'h7FFF_7FFF_7FFF));
    plan.push_back(write_step(CFG_COEF_BOTTOM, 48'h7FFF_7FFF_7FFF));
    plan.push_back(pixel_step(8'd255, 1'b1, CHK_NONE, '0));
    for (int k = 0; k < 7; k++) plan.push_back(pixel_step(8'd255, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd255, 1'b0, CHK_TYPED,
        '{frame_last: 1'b1, row_last: 1'b1, saturated: 1'b1, pixel: 8'd255}));
    // Most negative taps; the next frame follows the wrap with no frame start.
    plan.push_back(write_step(CFG_COEF_TOP, 48'h8000_8000_8000));
    plan.push_back(write_step(CFG_COEF_MID, 48'h8000_8000_8000));
    plan.push_back(write_step(CFG_COEF_BOTTOM, 48'h8000_8000_8000));
    for (int k = 0; k < 8; k++)
      plan.push_back(pixel_step((k % 2) ? 8'd255 : 8'd0, 1'b0, CHK_NONE, '0));
    plan.push_back(pixel_step(8'd0, 1'b0, CHK_TYPED,
        '{frame_last: 1'b1, row_last: 1'b1, saturated: 1'b1, pixel: 8'd0}));
    // Writes to unused indexes must leave every register alone.
    plan.push_back(write_step(CFG_SPARE_LO, '1));
    plan.push_back(write_step(CFG_SPARE_HI, 48'h0003_0003_0003));

    pixels_sent = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        if (pixels_sent) settle();
        pixels_sent = 1'b0;
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].pix, plan[i].sof, plan[i].chk, plan[i].want);
        pixels_sent = 1'b1;
      end
    end

    // Random part: mostly whole frames with random content, some cut short,
    // some restarted mid-frame, and registers changed between phases.
    ph = 0;
    rnd_words = 0;
    while (ph < 7 || rnd_words < RANDOM_WORDS) begin
      settle();
      tx_gappy = ($urandom_range(0, 3) != 0);
      rx_mode = rx_pace_e'($urandom_range(0, 2));
      tone = ($urandom_range(0, 4) < 3) ? TONE_ANY : tone_e'($urandom_range(1, 2));

      old_w = eff_width(img_w);
      write_w = 1'b1;
      pick = $urandom_range(0, 9);
      if (ph == WIDE_PHASE) new_w = '1;              // clamps to the line store size
      else if (old_w <= 40 && $urandom_range(0, 2) != 0) write_w = 1'b0;
      else if (pick == 0) new_w = WIDTH_W'($urandom_range(0, 2));
      else if (pick == 1) new_w = WIDTH_W'($urandom_range(13, 40));
      else new_w = WIDTH_W'($urandom_range(3, 12));
      if (!write_w) new_w = img_w;
      // A changed line width is safe mid-frame only when the column count already
      // lies past it, so the row wraps at once; otherwise restart the frame.
      need_sof = (eff_width(new_w) != old_w) && (col_cnt != 0 || row_cnt != 0) &&
                 (col_cnt < eff_width(new_w));

      write_h = 1'b1;
      if (ph == WIDE_PHASE) new_h = 16'd3;
      else if (ph == TALL_PHASE) new_h = '1;
      else if (eff_height(img_h) <= 8 && $urandom_range(0, 2) != 0) write_h = 1'b0;
      else if ($urandom_range(0, 9) == 0) new_h = HEIGHT_W'($urandom_range(0, 2));
      else new_h = HEIGHT_W'($urandom_range(3, 8));

      if ($urandom_range(0, 1)) write_reg(CFG_COEF_TOP, make_coef_row());
      if ($urandom_range(0, 1)) write_reg(CFG_COEF_MID, make_coef_row());
      if ($urandom_range(0, 1)) write_reg(CFG_COEF_BOTTOM, make_coef_row());
      if (write_w) write_reg(CFG_WIDTH, CFG_DATA_W'(new_w));
      if (write_h) write_reg(CFG_HEIGHT, CFG_DATA_W'(new_h));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  CFG_DATA_W'({$urandom, $urandom}));

      w_e = eff_width(img_w);
      h_e = eff_height(img_h);
      if (ph == WIDE_PHASE) begin
        words = $urandom_range(16, 48);
      end else if (ph == TALL_PHASE) begin
        words = w_e * 6 + $urandom_range(0, w_e - 1);
      end else begin
        words = $urandom_range(1, 3) * w_e * h_e;
        if ($urandom_range(0, 3) == 0) words += $urandom_range(1, w_e * h_e - 1);
      end

      for (int n = 0; n < words; n++) begin
        if (n == 0) sof = need_sof || ($urandom_range(0, 1) == 1);
        else if (col_cnt == 0 && row_cnt == 0) sof = $urandom_range(0, 1);
        else sof = (ph != WIDE_PHASE) && ($urandom_range(0, 199) == 0);
        send_pixel(make_pixel(tone), sof, CHK_MODEL, '0);
      end
      rnd_words += words;
      ph++;
    end

    settle();
    fault_count += awaited_results.size();
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
